/* design/crs_pkg.sv */
// Shared types and constants for the cursor ring sequence block.
package crs_pkg;

	// Request operation codes
	localparam logic [2:0] KIND_PUSH_BEFORE = 3'd0;
	localparam logic [2:0] KIND_PUSH_AFTER  = 3'd1;
	localparam logic [2:0] KIND_REMOVE      = 3'd2;
	localparam logic [2:0] KIND_ROTATE      = 3'd3;
	localparam logic [2:0] KIND_CLEAR       = 3'd4;
	localparam logic [2:0] KIND_QUERY       = 3'd5;

	// Response status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// Width of the rotation step and of the counter over its bits
	localparam int STEP_W     = 16;
	localparam int STEP_CNT_W = 4;

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        value;
		logic signed [15:0] step;
	} req_t;

	typedef struct packed {
		logic [31:0] current_value;
		logic [4:0]  element_total;
		logic        is_empty;
		logic [1:0]  status;
	} rsp_t;

	// Source select for one storage cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_LOAD       = 2'd1,
		CELL_FROM_LEFT  = 2'd2,
		CELL_FROM_RIGHT = 2'd3
	} cell_sel_t;

endpackage

/* design/crs_cell.sv */
// One storage cell of the element chain, loading from a neighbor or a new value.
module crs_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  crs_pkg::cell_sel_t    sel,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	input  logic [DATA_WIDTH-1:0] load,
	output logic [DATA_WIDTH-1:0] data_q
);

	// Take the selected source, or hold
	always_ff @(posedge clk) begin
		unique case (sel)
			crs_pkg::CELL_LOAD:       data_q <= load;
			crs_pkg::CELL_FROM_LEFT:  data_q <= left;
			crs_pkg::CELL_FROM_RIGHT: data_q <= right;
			default:                  data_q <= data_q;
		endcase
	end

endmodule

/* design/crs_mod.sv */
// Bit-serial remainder unit: step magnitude modulo element count, one bit a cycle.
module crs_mod #(
	parameter int CW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [crs_pkg::STEP_W-1:0] dividend,
	input  logic [CW-1:0]              divisor,
	output logic                       done,
	output logic [CW-1:0]              rem
);

	logic                           busy_q;
	logic                           done_q;
	logic [crs_pkg::STEP_CNT_W-1:0] cnt_q;
	logic [crs_pkg::STEP_W-1:0]     num_q;
	logic [CW-1:0]                  den_q;
	logic [CW-1:0]                  rem_q;
	logic [CW:0]                    trial;
	logic [CW-1:0]                  rem_next;

	// Shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial = {rem_q, num_q[crs_pkg::STEP_W-1]};
		if (trial >= {1'b0, den_q}) begin
			rem_next = CW'(trial - {1'b0, den_q});
		end else begin
			rem_next = trial[CW-1:0];
		end
	end

	// Control: count through the dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == crs_pkg::STEP_CNT_W'(crs_pkg::STEP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and shifted dividend
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[crs_pkg::STEP_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* design/cursor_ring_sequence_unit.sv */
// Top level of the cursor ring sequence: control, cell chain and response register.
// A request passes from idle to apply and then to respond, where the response is loaded;
// a rotate on a non-empty ring first waits in divide for the bit-serial remainder unit,
// which spends one cycle per step bit. Throughput: one request in flight; a new request is
// taken once the response is loaded, which rsp_stall can hold off.
// Reset: arst_n clears the count, cursor, control and response valid; cells hold no reset.
module cursor_ring_sequence_unit #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  crs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output crs_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_DIV   = 4'b0010,
		S_APPLY = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t                state_q;
	crs_pkg::req_t         req_q;
	logic [CW-1:0]         count_q;
	logic [PW-1:0]         cursor_q;
	logic                  dropped_q;
	logic                  rsp_valid_q;
	crs_pkg::rsp_t         rsp_q;

	logic                  accept;
	logic                  rsp_load;
	logic                  div_start;
	logic                  div_done;
	logic [CW-1:0]         div_rem;
	logic [crs_pkg::STEP_W-1:0] step_mag;

	logic                  apply;
	logic                  full;
	logic                  empty;
	logic [CW-1:0]         count_d;
	logic [PW-1:0]         cursor_d;
	logic                  dropped_d;
	logic                  do_ins;
	logic                  do_rem;
	logic [CW-1:0]         ins_pos;
	logic [CW-1:0]         rot_add;
	logic [CW:0]           rot_sum;
	logic [CW:0]           rot_wrap;
	logic [PW-1:0]         rot_pos;

	logic [DATA_WIDTH-1:0] new_data;
	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
	crs_pkg::cell_sel_t    cell_sel [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);
	assign apply     = (state_q == S_APPLY);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);

	// Start the remainder unit on a rotate of a non-empty ring
	assign div_start = accept && (req.kind == crs_pkg::KIND_ROTATE) && !empty;
	assign step_mag  = req.step[crs_pkg::STEP_W-1] ?
		crs_pkg::STEP_W'(0 - $unsigned(req.step)) : $unsigned(req.step);

	crs_mod #(
		.CW(CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (step_mag),
		.divisor  (count_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Resolve the new cursor after rotation, forward or backward
	always_comb begin
		rot_add  = req_q.step[crs_pkg::STEP_W-1] ? CW'(count_q - div_rem) : div_rem;
		rot_sum  = {1'b0, CW'(cursor_q)} + {1'b0, rot_add};
		rot_wrap = (rot_sum >= {1'b0, count_q}) ? (rot_sum - {1'b0, count_q}) : rot_sum;
		rot_pos  = rot_wrap[PW-1:0];
	end

	// Work out the next count, cursor and chain operation
	always_comb begin
		count_d   = count_q;
		cursor_d  = cursor_q;
		dropped_d = 1'b0;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		ins_pos   = '0;
		unique case (req_q.kind)
			crs_pkg::KIND_PUSH_BEFORE, crs_pkg::KIND_PUSH_AFTER: begin
				if (full) begin
					dropped_d = 1'b1;
				end else if (empty) begin
					do_ins   = 1'b1;
					ins_pos  = '0;
					cursor_d = '0;
					count_d  = count_q + 1'b1;
				end else if (req_q.kind == crs_pkg::KIND_PUSH_BEFORE) begin
					do_ins   = 1'b1;
					ins_pos  = CW'(cursor_q);
					cursor_d = cursor_q + 1'b1;
					count_d  = count_q + 1'b1;
				end else begin
					do_ins   = 1'b1;
					ins_pos  = CW'(cursor_q) + 1'b1;
					count_d  = count_q + 1'b1;
				end
			end
			crs_pkg::KIND_REMOVE: begin
				if (!empty) begin
					do_rem  = 1'b1;
					count_d = count_q - 1'b1;
					if (CW'(cursor_q) >= count_d) begin
						cursor_d = '0;
					end
				end
			end
			crs_pkg::KIND_ROTATE: begin
				if (!empty) begin
					cursor_d = rot_pos;
				end
			end
			crs_pkg::KIND_CLEAR: begin
				count_d  = '0;
				cursor_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Pick each cell's source: open a slot on insert, close the gap on remove
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_sel[i] = crs_pkg::CELL_HOLD;
			if (apply && do_ins) begin
				if (CW'(i) == ins_pos) begin
					cell_sel[i] = crs_pkg::CELL_LOAD;
				end else if (CW'(i) > ins_pos && CW'(i) <= count_q) begin
					cell_sel[i] = crs_pkg::CELL_FROM_LEFT;
				end
			end else if (apply && do_rem) begin
				if (CW'(i) >= CW'(cursor_q) && (CW'(i) + 1'b1) < count_q) begin
					cell_sel[i] = crs_pkg::CELL_FROM_RIGHT;
				end
			end
		end
	end

	assign new_data = DATA_WIDTH'(req_q.value);

	// Chain of cells, each wired to its two neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_chain
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;
		if (g == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_left
			assign left_data = cell_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_right
			assign right_data = cell_q[g+1];
		end
		crs_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk    (clk),
			.sel    (cell_sel[g]),
			.left   (left_data),
			.right  (right_data),
			.load   (new_data),
			.data_q (cell_q[g])
		);
	end

	assign rd_data = cell_q[cursor_q];

	// Sequence the request through divide, apply and respond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cursor_q  <= '0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= div_start ? S_DIV : S_APPLY;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					count_q   <= count_d;
					cursor_q  <= cursor_d;
					dropped_q <= dropped_d;
					state_q   <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			if (empty) begin
				rsp_q.current_value <= '0;
				rsp_q.element_total <= '0;
				rsp_q.is_empty      <= 1'b1;
				rsp_q.status        <= dropped_q ? crs_pkg::STATUS_FULL : crs_pkg::STATUS_EMPTY;
			end else begin
				rsp_q.current_value <= 32'(rd_data);
				rsp_q.element_total <= 5'(count_q);
				rsp_q.is_empty      <= 1'b0;
				rsp_q.status        <= dropped_q ? crs_pkg::STATUS_FULL : crs_pkg::STATUS_OK;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// Cursor points at a held element, or at zero when empty
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && cursor_q == '0) || (!empty && CW'(cursor_q) < count_q))
		else $error("cursor outside the held elements");

	// Remainder completes only while a rotate waits for it
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("remainder done outside divide state");

	// Empty response carries a zero count and value
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_empty) |-> (rsp.element_total == '0 && rsp.current_value == '0))
		else $error("empty response with nonzero fields");

endmodule

/* dv/cursor_ring_sequence_unit_tb.sv */
// Self-checking testbench for the cursor ring sequence unit: directed and random requests.
module cursor_ring_sequence_unit_tb;

	localparam int         CAPACITY      = 16;
	localparam int         IDLE_LIMIT    = 2000;
	localparam int         DRAIN_CYCLES  = 40;
	localparam int         RANDOM_ITEMS  = 520;
	// Kind codes with no operation of their own; the block treats them as query
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	typedef enum {TRAFFIC_GROW, TRAFFIC_SHRINK, TRAFFIC_CHURN} traffic_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	crs_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	crs_pkg::rsp_t rsp;

	// Predicted ring contents, kept compacted in ring order
	logic [31:0] ring_cells [CAPACITY];
	int unsigned ring_count  = 0;
	int unsigned ring_cursor = 0;

	crs_pkg::rsp_t pending_views [$];
	int unsigned   mismatch_count = 0;
	int unsigned   rsp_hold       = 0;
	int unsigned   idle_cycles    = 0;
	bit            no_idle        = 1'b0;

	cursor_ring_sequence_unit #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #10 clk = ~clk;

	// Draw the wait before the next request or response
	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, 19);
	endfunction

	// Apply one request to the predicted ring and return the view it should report
	function automatic crs_pkg::rsp_t advance_ring(crs_pkg::req_t r);
		crs_pkg::rsp_t view;
		logic          dropped;
		int unsigned   pos;
		int unsigned   shift;
		int            signed_step;
		int            i;
		dropped = 1'b0;
		case (r.kind)
			crs_pkg::KIND_PUSH_BEFORE, crs_pkg::KIND_PUSH_AFTER: begin
				if (ring_count >= CAPACITY) begin
					dropped = 1'b1;
				end else begin
					// Open a slot at the insert point and shift the tail up
					if (ring_count == 0)
						pos = 0;
					else if (r.kind == crs_pkg::KIND_PUSH_AFTER)
						pos = ring_cursor + 1;
					else
						pos = ring_cursor;
					for (i = ring_count; i > pos; i--)
						ring_cells[i] = ring_cells[i - 1];
					ring_cells[pos] = r.value;
					if (ring_count != 0 && r.kind == crs_pkg::KIND_PUSH_BEFORE)
						ring_cursor++;
					ring_count++;
				end
			end
			crs_pkg::KIND_REMOVE: begin
				if (ring_count != 0) begin
					for (i = ring_cursor; i + 1 < ring_count; i++)
						ring_cells[i] = ring_cells[i + 1];
					ring_count--;
					if (ring_cursor >= ring_count)
						ring_cursor = 0;
				end
			end
			crs_pkg::KIND_ROTATE: begin
				if (ring_count != 0) begin
					signed_step = r.step;
					if (signed_step < 0) begin
						shift       = (-signed_step) % ring_count;
						ring_cursor = (ring_cursor + ring_count - shift) % ring_count;
					end else begin
						shift       = signed_step % ring_count;
						ring_cursor = (ring_cursor + shift) % ring_count;
					end
				end
			end
			crs_pkg::KIND_CLEAR: begin
				ring_count  = 0;
				ring_cursor = 0;
			end
			default: ;
		endcase
		if (ring_count == 0) begin
			view.current_value = '0;
			view.element_total = '0;
			view.is_empty      = 1'b1;
			view.status        = dropped ? crs_pkg::STATUS_FULL : crs_pkg::STATUS_EMPTY;
		end else begin
			view.current_value = ring_cells[ring_cursor];
			view.element_total = 5'(ring_count);
			view.is_empty      = 1'b0;
			view.status        = dropped ? crs_pkg::STATUS_FULL : crs_pkg::STATUS_OK;
		end
		return view;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Present one request, hold it until taken, then record its predicted view
	task automatic send_request(input logic [2:0] kind, input logic [31:0] value,
			input logic signed [15:0] step);
		crs_pkg::req_t item;
		int unsigned   gap;
		gap = draw_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.kind  = kind;
		item.value = value;
		item.step  = step;
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_views.push_back(advance_ring(item));
	endtask

	// Compare each accepted response with the oldest predicted view, then stall at random
	always @(posedge clk) begin : check_rsp
		crs_pkg::rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_views.size() == 0) begin
				$error("response with no request outstanding: %h", rsp);
				mismatch_count++;
			end else begin
				want = pending_views.pop_front();
				check_field("current_value", want.current_value, rsp.current_value);
				check_field("element_total", 32'(want.element_total), 32'(rsp.element_total));
				check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
				check_field("status", 32'(want.status), 32'(rsp.status));
			end
			rsp_hold = draw_gap();
			rsp_stall <= (rsp_hold != 0);
		end else if (rsp_hold != 0) begin
			rsp_hold--;
			rsp_stall <= (rsp_hold != 0);
		end
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Operations on an empty ring, a single push and removal of the last element
	task automatic test_empty_ring();
		send_request(crs_pkg::KIND_QUERY, 32'h0, 16'sd0);
		send_request(crs_pkg::KIND_REMOVE, 32'h0, 16'sd0);
		send_request(crs_pkg::KIND_ROTATE, 32'h0, 16'sh8000);
		send_request(crs_pkg::KIND_PUSH_AFTER, 32'hFFFF_FFFF, 16'sd0);
		send_request(crs_pkg::KIND_REMOVE, 32'h0, 16'sd0);
	endtask

	// Fill with both push kinds, then push into a full ring
	task automatic test_fill_to_capacity();
		int          i;
		logic [31:0] value;
		for (i = 0; i < CAPACITY; i++) begin
			if (i == 0)
				value = 32'h0;
			else if (i == 1)
				value = 32'hFFFF_FFFF;
			else
				value = $urandom;
			send_request(i[0] ? crs_pkg::KIND_PUSH_AFTER : crs_pkg::KIND_PUSH_BEFORE,
				value, 16'sd0);
		end
		send_request(crs_pkg::KIND_PUSH_BEFORE, $urandom, 16'sd0);
		send_request(crs_pkg::KIND_PUSH_AFTER, $urandom, 16'sd0);
	endtask

	// Rotate by zero, the largest step and the most negative step (a whole turn when full)
	task automatic test_rotate_extremes();
		send_request(crs_pkg::KIND_ROTATE, 32'h0, 16'sd0);
		send_request(crs_pkg::KIND_ROTATE, 32'h0, 16'sh7FFF);
		send_request(crs_pkg::KIND_ROTATE, 32'h0, 16'sh8000);
	endtask

	// Spare kind codes, a removal in a full ring and clear
	task automatic test_spare_kinds_and_clear();
		send_request(KIND_SPARE_LO, $urandom, 16'sd5);
		send_request(KIND_SPARE_HI, $urandom, -16'sd5);
		send_request(crs_pkg::KIND_REMOVE, 32'h0, 16'sd0);
		send_request(crs_pkg::KIND_CLEAR, 32'h0, 16'sd0);
	endtask

	// Bursts that grow, shrink or churn the ring, with random content and idling
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned        n;
		int unsigned        roll;
		int unsigned        burst_left;
		int                 small_step;
		traffic_t           mode;
		logic [2:0]         kind;
		logic [31:0]        value;
		logic signed [15:0] step;
		burst_left = 0;
		mode       = TRAFFIC_GROW;
		for (n = 0; n < n_items; n++) begin
			// Start a new burst with its own mix and idling
			if (burst_left == 0) begin
				mode       = traffic_t'($urandom_range(0, 2));
				burst_left = $urandom_range(10, 40);
				no_idle    = ($urandom_range(0, 3) == 0);
			end
			burst_left--;

			roll = $urandom_range(0, 99);
			case (mode)
				TRAFFIC_GROW:
					kind = roll < 40 ? crs_pkg::KIND_PUSH_BEFORE :
						roll < 80 ? crs_pkg::KIND_PUSH_AFTER :
						roll < 88 ? crs_pkg::KIND_ROTATE : roll < 94 ? crs_pkg::KIND_REMOVE :
						roll < 98 ? crs_pkg::KIND_QUERY : KIND_SPARE_LO;
				TRAFFIC_SHRINK:
					kind = roll < 45 ? crs_pkg::KIND_REMOVE : roll < 60 ? crs_pkg::KIND_ROTATE :
						roll < 70 ? crs_pkg::KIND_PUSH_BEFORE :
						roll < 80 ? crs_pkg::KIND_PUSH_AFTER :
						roll < 88 ? crs_pkg::KIND_QUERY : roll < 93 ? crs_pkg::KIND_CLEAR :
						KIND_SPARE_HI;
				default:
					kind = roll < 20 ? crs_pkg::KIND_PUSH_BEFORE :
						roll < 40 ? crs_pkg::KIND_PUSH_AFTER :
						roll < 60 ? crs_pkg::KIND_ROTATE : roll < 80 ? crs_pkg::KIND_REMOVE :
						roll < 92 ? crs_pkg::KIND_QUERY : roll < 96 ? crs_pkg::KIND_CLEAR :
						roll < 98 ? KIND_SPARE_LO : KIND_SPARE_HI;
			endcase

			roll = $urandom_range(0, 9);
			if (roll == 0)
				value = 32'h0;
			else if (roll == 1)
				value = 32'hFFFF_FFFF;
			else
				value = $urandom;

			// Short steps for 40 percent, some extremes and whole turns, the rest full range
			roll = $urandom_range(0, 9);
			if (roll < 4) begin
				small_step = int'($urandom_range(0, 80)) - 40;
				step       = 16'(small_step);
			end else if (roll < 5) begin
				case ($urandom_range(0, 3))
					0:       step = 16'sh7FFF;
					1:       step = 16'sh8000;
					2:       step = 16'sd0;
					default: step = 16'(CAPACITY * $urandom_range(1, 4));
				endcase
			end else begin
				step = 16'($urandom);
			end

			send_request(kind, value, step);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ring();
		test_fill_to_capacity();
		test_rotate_extremes();
		test_spare_kinds_and_clear();
		test_random_traffic(RANDOM_ITEMS);
		req_valid <= 1'b0;

		// Drain outstanding responses, then watch for strays
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
design/crs_pkg.sv
design/crs_cell.sv
design/crs_mod.sv
design/cursor_ring_sequence_unit.sv
dv/cursor_ring_sequence_unit_tb.sv
